// File: sv/key_event_autorepeat_macros.svh
// Assertion helpers for the key event datapath.
`ifndef KEY_EVENT_AUTOREPEAT_MACROS_SVH
`define KEY_EVENT_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/kea_pkg.sv
package kea_pkg;

  localparam int unsigned KEY_W  = 8;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [KEY_W-1:0]  HANGUL_KEY = 8'h15;
  localparam logic [TICK_W-1:0] NEVER      = 32'hFFFF_FFFF;

  localparam logic [CFG_W-1:0] FIRST_DELAY_RST     = 16'd400;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_FIRST_DELAY     = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_SAMPLE   = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key_code;
    logic [ID_W-1:0]   key_id;
    logic              key_down;
    logic              shift_down;
    logic [TICK_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [ID_W-1:0]  out_id;
    logic             out_pressed;
    logic             out_shift;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              was_down;
    logic [TICK_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] first_delay;
    logic [CFG_W-1:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_empty;
  } dp_status_t;

endpackage

// File: sv/kea_in_if.sv
interface kea_in_if;
  import kea_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  key_code;
  logic [ID_W-1:0]   key_id;
  logic              key_down;
  logic              shift_down;
  logic [TICK_W-1:0] now;

  modport source (
    output valid, op, key_code, key_id, key_down, shift_down, now,
    input  ready
  );

  modport sink (
    input  valid, op, key_code, key_id, key_down, shift_down, now,
    output ready
  );

endinterface

// File: sv/kea_out_if.sv
interface kea_out_if;
  import kea_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_key;
  logic [ID_W-1:0]  out_id;
  logic             out_pressed;
  logic             out_shift;
  logic             last;

  modport source (
    output valid, out_key, out_id, out_pressed, out_shift, last,
    input  ready
  );

  modport sink (
    input  valid, out_key, out_id, out_pressed, out_shift, last,
    output ready
  );

endinterface

// File: sv/key_event_autorepeat.sv
// Flow: an input transfer registers the item and reads its table entry; the commit then
//   loads the item's results into the result buffer. An item gives 0 to 2 results.
// Each item takes a table read, then a write-back; the write-back waits until the output
//   buffer is empty, and no new item is taken until the write-back is done.
// Reset: asynchronous, active low; clears registrations, levels, deadlines and the buffer,
//   and loads first_delay 400 and repeat_interval 100. No clearing pass is needed.
module key_event_autorepeat #(
  parameter int unsigned KEY_COUNT = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kea_in_if.sink                     key_in_i,
  kea_out_if.source                  evt_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kea_pkg::ADDR_W-1:0] paddr,
  input  logic [kea_pkg::DATA_W-1:0] pwdata,
  output logic [kea_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import kea_pkg::*;

  // Structure:
  //   kea_cfg   - APB register file for the two timing registers.
  //   kea_ctrl  - two-state sequencer: take a transfer and start the table read,
  //               then commit the write-back once the result buffer is empty.
  //   kea_dpath - key table and two-slot result buffer. Registered and
  //               written flags sit in flip-flops; ID, level and deadline live
  //               in one memory read at transfer and written at commit.
  //
  // A sample of a registered key gives an edge result on a level change, then
  // a repeat press when a non-Hangul key is held and the tick reached the deadline.
  // The item stays in the datapath until its results are queued, so the
  // next transfer can land while earlier results still wait to be taken.

  cfg_t       cfg;
  item_t      item;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  res_t       res;

  // Gather the input payload into one bundle for the datapath.
  assign item.op         = key_in_i.op;
  assign item.key_code   = key_in_i.key_code;
  assign item.key_id     = key_in_i.key_id;
  assign item.key_down   = key_in_i.key_down;
  assign item.shift_down = key_in_i.shift_down;
  assign item.now        = key_in_i.now;

  kea_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (key_in_i.valid),
    .in_ready_o (key_in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kea_dpath #(
    .KEY_COUNT (KEY_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (evt_out_o.valid),
    .out_ready_i (evt_out_o.ready),
    .out_res_o   (res)
  );

  // Drive the result payload from the head of the buffer.
  assign evt_out_o.out_key     = res.out_key;
  assign evt_out_o.out_id      = res.out_id;
  assign evt_out_o.out_pressed = res.out_pressed;
  assign evt_out_o.out_shift   = res.out_shift;
  assign evt_out_o.last        = res.last;

endmodule

// File: sv/kea_cfg.sv
module kea_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kea_pkg::ADDR_W-1:0]    paddr,
  input  logic [kea_pkg::DATA_W-1:0]    pwdata,
  output logic [kea_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output kea_pkg::cfg_t                 cfg_o
);
  import kea_pkg::*;

  logic [CFG_W-1:0] first_delay_q;
  logic [CFG_W-1:0] repeat_interval_q;
  logic             wr_en;
  reg_idx_e         sel;

  assign pready = 1'b1;
  assign sel    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q     <= FIRST_DELAY_RST;
      repeat_interval_q <= REPEAT_INTERVAL_RST;
    end else if (wr_en) begin
      case (sel)
        REG_FIRST_DELAY:     first_delay_q     <= pwdata[CFG_W-1:0];
        REG_REPEAT_INTERVAL: repeat_interval_q <= pwdata[CFG_W-1:0];
        default:             first_delay_q     <= first_delay_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_FIRST_DELAY:     prdata = {{(DATA_W-CFG_W){1'b0}}, first_delay_q};
      REG_REPEAT_INTERVAL: prdata = {{(DATA_W-CFG_W){1'b0}}, repeat_interval_q};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.first_delay     = first_delay_q;
  assign cfg_o.repeat_interval = repeat_interval_q;

endmodule

// File: sv/kea_ctrl.sv
module kea_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kea_pkg::dp_status_t status_i,
  output kea_pkg::ctrl_cmd_t  cmd_o
);
  import kea_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold until the result buffer has drained
        if (status_i.out_empty) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: sv/kea_dpath.sv
`include "key_event_autorepeat_macros.svh"

module kea_dpath #(
  parameter int unsigned KEY_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kea_pkg::cfg_t       cfg_i,
  input  kea_pkg::item_t      item_i,
  input  kea_pkg::ctrl_cmd_t  cmd_i,
  output kea_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kea_pkg::res_t       out_res_o
);
  import kea_pkg::*;

  localparam int unsigned IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // held item
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [ID_W-1:0]   id_q;
  logic              down_q;
  logic              shift_q;
  logic              in_range_q;
  logic [TICK_W-1:0] now_q;
  logic [TICK_W-1:0] now_fd_q;
  logic [TICK_W-1:0] now_ri_q;

  // key table
  logic [KEY_COUNT-1:0] reg_q;
  logic [KEY_COUNT-1:0] touched_q;
  entry_t               mem_q [KEY_COUNT];
  entry_t               rd_q;

  // result buffer
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  res_t       slot_q [2];
  res_t       slot_d [2];

  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] idx_q;
  logic             in_range;
  entry_t           ent;
  entry_t           wr_ent;
  logic             is_reg;
  logic             is_clr;
  logic             is_smp;
  logic             key_reg;
  logic             edge_hit;
  logic             rep_hit;
  logic [TICK_W-1:0] dl1;
  res_t             edge_res;
  res_t             rep_res;
  logic             pop;

  assign in_idx   = item_i.key_code[IDX_W-1:0];
  assign idx_q    = key_q[IDX_W-1:0];
  assign in_range = {1'b0, item_i.key_code} < (KEY_W+1)'(KEY_COUNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= item_i.op;
      key_q      <= item_i.key_code;
      id_q       <= item_i.key_id;
      down_q     <= item_i.key_down;
      shift_q    <= item_i.shift_down;
      in_range_q <= in_range;
      now_q      <= item_i.now;
      now_fd_q   <= item_i.now + {{(TICK_W-CFG_W){1'b0}}, cfg_i.first_delay};
      now_ri_q   <= item_i.now + {{(TICK_W-CFG_W){1'b0}}, cfg_i.repeat_interval};
      rd_q       <= mem_q[in_idx];
    end
  end

  // an entry never written reads as the all-zero reset value
  assign key_reg = reg_q[idx_q];
  assign ent     = touched_q[idx_q] ? rd_q : '0;
  assign is_clr  = (op_q == OP_CLEAR);
  assign is_reg  = (op_q == OP_REGISTER) && in_range_q;
  assign is_smp  = (op_q == OP_SAMPLE) && in_range_q && key_reg;

  always_comb begin
    edge_hit = (down_q != ent.was_down);
    dl1      = ent.deadline;
    if (edge_hit) begin
      dl1 = down_q ? now_fd_q : NEVER;
    end
    rep_hit = (key_q != HANGUL_KEY) && down_q && (now_q >= dl1);

    wr_ent = ent;
    if (is_reg) begin
      if (!key_reg) begin
        wr_ent.id = id_q;
      end
      if (ent.deadline == '0) begin
        wr_ent.deadline = NEVER;
      end
    end else begin
      wr_ent.was_down = down_q;
      wr_ent.deadline = rep_hit ? now_ri_q : dl1;
    end

    edge_res.out_key     = key_q;
    edge_res.out_id      = ent.id;
    edge_res.out_pressed = down_q;
    edge_res.out_shift   = shift_q;
    edge_res.last        = !rep_hit;

    rep_res.out_key     = key_q;
    rep_res.out_id      = ent.id;
    rep_res.out_pressed = 1'b1;
    rep_res.out_shift   = shift_q;
    rep_res.last        = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (is_reg || is_smp)) begin
      mem_q[idx_q] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q     <= '0;
      touched_q <= '0;
    end else if (cmd_i.commit) begin
      if (is_clr) begin
        reg_q <= '0;
      end else if (is_reg) begin
        reg_q[idx_q]     <= 1'b1;
        touched_q[idx_q] <= 1'b1;
      end
    end
  end

  // Result buffer: loaded only when empty, so load and pop never meet.
  assign pop = (cnt_q != 2'd0) && out_ready_i;

  always_comb begin
    cnt_d     = cnt_q;
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (cmd_i.commit) begin
      if (is_smp) begin
        cnt_d = {edge_hit && rep_hit, edge_hit ^ rep_hit};
      end
      slot_d[0] = edge_hit ? edge_res : rep_res;
      slot_d[1] = rep_res;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign out_valid_o        = (cnt_q != 2'd0);
  assign out_res_o          = slot_q[0];
  assign status_o.out_empty = (cnt_q == 2'd0);

  `KEA_ASSERT_IMPL(a_commit_empty, clk_i, rst_ni, cmd_i.commit, cnt_q == 2'd0, "commit while results pending")
  `KEA_ASSERT_IMPL(a_pair_order, clk_i, rst_ni, cnt_q == 2'd2, !slot_q[0].last && slot_q[1].last, "edge and repeat out of order")
  `KEA_ASSERT_NEXT(a_reg_sets_flag, clk_i, rst_ni, cmd_i.commit && is_reg, reg_q[idx_q] && touched_q[idx_q], "register did not mark key")

endmodule

// File: verif/key_event_autorepeat_tb.sv
module key_event_autorepeat_tb;
  import kea_pkg::*;

  localparam int unsigned KEYS = 256;
  // Op code the block must ignore.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Hold-off of the event sink, in cycles, long enough to back up the block.
  localparam int unsigned SINK_HOLD = 300;
  // Quiet cycles after the last event before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  kea_in_if  key_in ();
  kea_out_if evt_out ();

  key_event_autorepeat i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_in_i  (key_in),
    .evt_out_o (evt_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock: period 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Typematic shadow of the block: config plus one table entry per key code.
  logic [CFG_W-1:0]  cfg_first_delay = FIRST_DELAY_RST;
  logic [CFG_W-1:0]  cfg_repeat_gap  = REPEAT_INTERVAL_RST;
  logic              key_armed [KEYS] = '{default: 1'b0};
  logic [ID_W-1:0]   key_tag   [KEYS] = '{default: '0};
  logic              key_held  [KEYS] = '{default: 1'b0};
  logic [TICK_W-1:0] key_due   [KEYS] = '{default: '0};

  item_t pending [$];     // items waiting for the driver
  res_t  events_due [$];  // key events the block still owes, oldest first
  int unsigned fails = 0;

  logic item_taken = 1'b0;  // an input transfer happened at the last rising edge
  logic calm       = 1'b0;  // suppress random idling on both sides
  logic hold_req   = 1'b0;  // ask the sink for one long hold-off
  logic hold_done  = 1'b0;
  int unsigned hold_left = 0;

  // Apply one accepted item to the shadow table and queue the events it causes:
  // the edge first, then a repeat press when the held key reaches its deadline.
  function automatic void typematic_step(item_t it);
    res_t ev;
    res_t evs [$];
    int unsigned k;
    k = it.key_code;
    case (it.op)
      OP_CLEAR: key_armed = '{default: 1'b0};  // levels and deadlines survive
      OP_REGISTER: begin
        if (!key_armed[k]) begin
          key_armed[k] = 1'b1;
          key_tag[k]   = it.key_id;
        end
        if (key_due[k] == '0) key_due[k] = NEVER;
      end
      OP_SAMPLE: begin
        if (key_armed[k]) begin
          if (it.key_down != key_held[k]) begin
            key_held[k] = it.key_down;
            key_due[k]  = it.key_down ? it.now + TICK_W'(cfg_first_delay) : NEVER;
            ev = '{out_key: it.key_code, out_id: key_tag[k], out_pressed: it.key_down,
                   out_shift: it.shift_down, last: 1'b0};
            evs = {evs, ev};
          end
          // Hangul never auto-repeats; deadline compare is unsigned on wrapped ticks.
          if (it.key_code != HANGUL_KEY && it.key_down && it.now >= key_due[k]) begin
            key_due[k] = it.now + TICK_W'(cfg_repeat_gap);
            ev = '{out_key: it.key_code, out_id: key_tag[k], out_pressed: 1'b1,
                   out_shift: it.shift_down, last: 1'b0};
            evs = {evs, ev};
          end
        end
      end
      default: ;
    endcase
    if (evs.size() != 0) evs[evs.size()-1].last = 1'b1;
    events_due = {events_due, evs};
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  // Driver: advance to the next pending item once the current one has transferred,
  // or idle now and then.
  always @(negedge clk_i) begin
    if (rst_ni && (!key_in.valid || item_taken)) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
        key_in.valid      <= 1'b1;
        key_in.op         <= pending[0].op;
        key_in.key_code   <= pending[0].key_code;
        key_in.key_id     <= pending[0].key_id;
        key_in.key_down   <= pending[0].key_down;
        key_in.shift_down <= pending[0].shift_down;
        key_in.now        <= pending[0].now;
        void'(pending.pop_front());
      end else begin
        key_in.valid <= 1'b0;
      end
    end
  end

  // Event sink: one long hold-off on request, random stalls otherwise.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      evt_out.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      evt_out.ready <= 1'b0;
      hold_left     <= SINK_HOLD;
      hold_done     <= 1'b1;
    end else begin
      evt_out.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Monitor: check event transfers against the oldest expectation, then predict
  // from the input transfer of the same edge.
  always @(posedge clk_i) begin
    res_t want;
    item_t got_item;
    if (rst_ni) begin
      if (evt_out.valid && evt_out.ready) begin
        if (events_due.size() == 0) begin
          $error("unexpected event: key 0x%0h id 0x%0h pressed %0b",
                 evt_out.out_key, evt_out.out_id, evt_out.out_pressed);
          fails++;
        end else begin
          want = events_due.pop_front();
          check_field("out_key", want.out_key, evt_out.out_key);
          check_field("out_id", want.out_id, evt_out.out_id);
          check_field("out_pressed", want.out_pressed, evt_out.out_pressed);
          check_field("out_shift", want.out_shift, evt_out.out_shift);
          check_field("last", want.last, evt_out.last);
        end
      end
      if (key_in.valid && key_in.ready) begin
        got_item = '{op: key_in.op, key_code: key_in.key_code, key_id: key_in.key_id,
                     key_down: key_in.key_down, shift_down: key_in.shift_down,
                     now: key_in.now};
        typematic_step(got_item);
      end
      item_taken <= key_in.valid && key_in.ready;
    end
  end

  task automatic push_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [ID_W-1:0] id,
                           logic down, logic shift, logic [TICK_W-1:0] tick);
    item_t it;
    it = '{op: op, key_code: key, key_id: id, key_down: down, shift_down: shift, now: tick};
    pending = {pending, it};
  endtask

  // APB write: setup, then access; the register takes the value when pready is seen.
  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_FIRST_DELAY) cfg_first_delay = val;
    else cfg_repeat_gap = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every item has transferred and every event has come out, then
  // let a zero-event item still in flight finish.
  task automatic drain();
    while (pending.size() != 0 || key_in.valid) @(posedge clk_i);
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  logic [KEY_W-1:0]  hot_keys [8];
  logic              typed_down [KEYS] = '{default: 1'b0};
  logic [TICK_W-1:0] tick = '0;

  // Typing traffic: mostly samples of a few registered keys with ticks moving
  // forward, some registrations and clears, and a share of raw noise.
  task automatic queue_typing(int unsigned count, int unsigned adv_max);
    int unsigned roll;
    logic [KEY_W-1:0] k;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if ($urandom_range(199) == 0) tick = NEVER - $urandom_range(2000);
      else tick = tick + $urandom_range(adv_max);
      if (roll < 4) begin
        push_item(OP_REGISTER, hot_keys[$urandom_range(7)], ID_W'($urandom), 1'b0, 1'b0,
                  tick);
      end else if (roll < 6) begin
        push_item(OP_CLEAR, KEY_W'($urandom), ID_W'($urandom), 1'($urandom),
                  1'($urandom), tick);
        // Mostly re-register the whole set right away so samples keep landing.
        if ($urandom_range(4) != 0)
          foreach (hot_keys[i])
            push_item(OP_REGISTER, hot_keys[i], ID_W'($urandom), 1'b0, 1'b0, tick);
      end else if (roll < 10) begin
        push_item(OP_W'($urandom_range(3)), KEY_W'($urandom), ID_W'($urandom),
                  1'($urandom), 1'($urandom), $urandom);
      end else begin
        k = hot_keys[$urandom_range(7)];
        if ($urandom_range(3) == 0) typed_down[k] = !typed_down[k];
        push_item(OP_SAMPLE, k, ID_W'($urandom), typed_down[k], 1'($urandom), tick);
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    key_in.valid       = 1'b0;
    key_in.op          = OP_REGISTER;
    key_in.key_code    = '0;
    key_in.key_id      = '0;
    key_in.key_down    = 1'b0;
    key_in.shift_down  = 1'b0;
    key_in.now         = '0;
    evt_out.ready      = 1'b0;
    hot_keys = '{8'h15, 8'h00, 8'hFF, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00};
    for (int i = 4; i < 8; i++) hot_keys[i] = KEY_W'($urandom);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pass at the reset delays (400 / 100).
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b1, 1'b0, 32'd10);    // unregistered: drop
    push_item(OP_REGISTER, 8'h41, 16'hFFFF, 1'b0, 1'b0, 32'd0);
    push_item(OP_REGISTER, 8'h41, 16'h0001, 1'b0, 1'b0, 32'd0);     // keeps bound ID
    push_item(OP_REGISTER, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd0);
    push_item(OP_REGISTER, 8'hFF, 16'h8000, 1'b0, 1'b0, 32'd0);
    push_item(OP_REGISTER, HANGUL_KEY, 16'h1234, 1'b0, 1'b0, 32'd0);
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b1, 1'b1, 32'd1000);  // press
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b1, 1'b1, 32'd1399);  // one tick short
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b1, 1'b0, 32'd1400);  // first repeat
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b0, 1'b1, 32'd1450);  // release
    push_item(OP_SAMPLE,   HANGUL_KEY, 16'h0000, 1'b1, 1'b0, 32'd0);
    push_item(OP_SAMPLE,   HANGUL_KEY, 16'h0000, 1'b1, 1'b0, 32'd5000);  // no repeat
    push_item(OP_SAMPLE,   8'hFF, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FF00);  // deadline wraps
    push_item(OP_SAMPLE,   8'hFF, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_UNUSED,   8'h41, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_CLEAR,    8'h00, 16'h0000, 1'b0, 1'b0, 32'd0);
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b1, 1'b0, 32'd2000);  // cleared: drop
    push_item(OP_REGISTER, 8'h41, 16'h5555, 1'b0, 1'b0, 32'd0);     // new ID after clear
    push_item(OP_REGISTER, 8'h00, 16'hAAAA, 1'b0, 1'b0, 32'd0);
    push_item(OP_SAMPLE,   8'h00, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_SAMPLE,   8'h41, 16'h0000, 1'b1, 1'b1, 32'd3000);
    push_item(OP_SAMPLE,   8'h00, 16'h0000, 1'b0, 1'b0, 32'd0);
    drain();

    // Zero delays: every press of a non-Hangul key repeats at once, as does every held sample.
    write_reg(REG_FIRST_DELAY, 16'd0);
    write_reg(REG_REPEAT_INTERVAL, 16'd0);
    foreach (hot_keys[i]) push_item(OP_REGISTER, hot_keys[i], ID_W'($urandom), 1'b0, 1'b0, tick);
    queue_typing(400, 50);
    drain();

    // Longest delays, with both sides running flat out.
    calm = 1'b1;
    write_reg(REG_FIRST_DELAY, 16'hFFFF);
    write_reg(REG_REPEAT_INTERVAL, 16'hFFFF);
    queue_typing(300, 40000);
    drain();
    calm = 1'b0;

    // Mid-range delays; the first round also holds the sink off to back up the block.
    for (int r = 0; r < 3; r++) begin
      write_reg(REG_FIRST_DELAY, CFG_W'($urandom_range(500, 1)));
      write_reg(REG_REPEAT_INTERVAL, CFG_W'($urandom_range(200, 1)));
      queue_typing(330, 200);
      if (r == 0) hold_req = 1'b1;
      drain();
    end

    if (fails == 0) begin
      $display("key_event_autorepeat_tb: PASS");
    end else begin
      $display("key_event_autorepeat_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("key_event_autorepeat_tb: FAIL");
    $finish;
  end

endmodule
